// ===== rtl/avr_pkg.sv =====
package avr_pkg;

    localparam int VectorWidth = 32;
    localparam int CoefWidth   = 16;
    localparam int AngleWidth  = 16;
    localparam int TrigStages  = 16;
    localparam int CoefFrac    = CoefWidth - 2;
    localparam int CordicGain  = 652032874;

    localparam int SumWidth    = VectorWidth + CoefWidth + 2;
    localparam int QprodWidth  = 2 * CoefWidth;

    typedef logic [1:0] op_t;
    localparam op_t OP_EULER = 2'd0;
    localparam op_t OP_QUAT  = 2'd1;
    localparam op_t OP_QUATT = 2'd2;

    typedef logic signed [CoefWidth-1:0]   coef_t;
    typedef logic signed [AngleWidth-1:0]  angle_t;
    typedef logic signed [VectorWidth-1:0] vec_t;

    typedef struct packed {
        op_t    op;
        angle_t roll_angle;
        angle_t pitch_angle;
        angle_t yaw_angle;
        coef_t  quat_w;
        coef_t  quat_x;
        coef_t  quat_y;
        coef_t  quat_z;
        vec_t   vec_x;
        vec_t   vec_y;
        vec_t   vec_z;
    } in_item_t;

    typedef struct packed {
        vec_t rot_x;
        vec_t rot_y;
        vec_t rot_z;
        logic saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [33:0] z;
        logic               neg;
    } cordic_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10679838;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335086;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41722;
            15: t = 32'd20861;
            16: t = 32'd10430;
            17: t = 32'd5215;
            18: t = 32'd2608;
            19: t = 32'd1304;
            20: t = 32'd652;
            21: t = 32'd326;
            22: t = 32'd163;
            23: t = 32'd81;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

    function automatic coef_t clamp_coef(input logic signed [QprodWidth+3:0] v);
        coef_t r;
        if (v > $signed({{(QprodWidth+4-CoefWidth){1'b0}}, {1'b0, {(CoefWidth-1){1'b1}}}}))
            r = {1'b0, {(CoefWidth-1){1'b1}}};
        else if (v < -$signed({{(QprodWidth+4-CoefWidth){1'b0}}, {1'b1, {(CoefWidth-1){1'b0}}}}))
            r = {1'b1, {(CoefWidth-1){1'b0}}};
        else
            r = v[CoefWidth-1:0];
        return r;
    endfunction

    function automatic coef_t mulr(input coef_t a, input coef_t b);
        logic signed [QprodWidth+3:0] p;
        p = (QprodWidth+4)'(a) * (QprodWidth+4)'(b);
        p = p + (QprodWidth+4)'(1 <<< (CoefFrac - 1));
        p = p >>> CoefFrac;
        return p[CoefWidth-1:0];
    endfunction

    function automatic coef_t quat_entry(input logic signed [QprodWidth-1:0] p,
                                         input logic signed [QprodWidth-1:0] q,
                                         input logic minus_one);
        logic signed [QprodWidth+3:0] e;
        e = ((QprodWidth+4)'(p) + (QprodWidth+4)'(q)) <<< 1;
        if (minus_one)
            e = e - ((QprodWidth+4)'(1) <<< (2 * CoefFrac));
        e = (e + ((QprodWidth+4)'(1) <<< (CoefFrac - 1))) >>> CoefFrac;
        return clamp_coef(e);
    endfunction

endpackage

// ===== rtl/avr_stream_if.sv =====
interface avr_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/attitude_vector_rotator.sv =====
// Channel  Dir  Payload                                     Handshake
// in_ch    in   op, angles, quaternion, vector              valid/ready
// out_ch   out  rot_x, rot_y, rot_z, saturated              valid/ready
//
// One transaction per cycle sustained while out_ch does not stall.
// Depth is set by the CORDIC input register and one micro-rotation stage per
// TrigStages, then trig/product stage, matrix stage, product stage, sum stage,
// saturating output register.
// rst_n clears every valid bit; payload registers are not reset.
// A stall on out_ch freezes the whole pipeline; nothing is lost or repeated.
module attitude_vector_rotator
    import avr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    avr_stream_if.sink   in_ch,
    avr_stream_if.source out_ch
);

    localparam int Depth = TrigStages + 6;

    logic advance;
    logic [Depth-1:0] vld_reg;

    assign advance      = !vld_reg[Depth-1] || out_ch.ready;
    assign in_ch.ready  = advance;
    assign out_ch.valid = vld_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[Depth-2:0], in_ch.valid};
    end

    // CORDIC front end and stages
    cordic_t  cor_reg [3][TrigStages+1];
    in_item_t itm_reg [TrigStages+1];
    cordic_t  cor_next [3][TrigStages+1];

    always_comb
    begin
        logic [31:0] u;
        logic signed [33:0] z;
        angle_t a;
        for (int k = 0; k < 3; k++)
        begin
            a = (k == 0) ? in_ch.data.roll_angle :
                (k == 1) ? in_ch.data.pitch_angle : in_ch.data.yaw_angle;
            u = {a, {(32-AngleWidth){1'b0}}};
            z = 34'(signed'(u));
            cor_next[k][0].neg = 1'b0;
            if (z > 34'sd1073741824)
            begin
                z = z - 34'sd2147483648;
                cor_next[k][0].neg = 1'b1;
            end
            else if (z < -34'sd1073741824)
            begin
                z = z + 34'sd2147483648;
                cor_next[k][0].neg = 1'b1;
            end
            cor_next[k][0].x = 35'(CordicGain);
            cor_next[k][0].y = '0;
            cor_next[k][0].z = z;
            for (int i = 1; i <= TrigStages; i++)
            begin
                cor_next[k][i].neg = cor_reg[k][i-1].neg;
                if (!cor_reg[k][i-1].z[33])
                begin
                    cor_next[k][i].x = cor_reg[k][i-1].x - (cor_reg[k][i-1].y >>> (i-1));
                    cor_next[k][i].y = cor_reg[k][i-1].y + (cor_reg[k][i-1].x >>> (i-1));
                    cor_next[k][i].z = cor_reg[k][i-1].z - 34'(atan_turn(i-1));
                end
                else
                begin
                    cor_next[k][i].x = cor_reg[k][i-1].x + (cor_reg[k][i-1].y >>> (i-1));
                    cor_next[k][i].y = cor_reg[k][i-1].y - (cor_reg[k][i-1].x >>> (i-1));
                    cor_next[k][i].z = cor_reg[k][i-1].z + 34'(atan_turn(i-1));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            itm_reg[0] <= in_ch.data;
            for (int i = 1; i <= TrigStages; i++)
                itm_reg[i] <= itm_reg[i-1];
            for (int k = 0; k < 3; k++)
                for (int i = 0; i <= TrigStages; i++)
                    cor_reg[k][i] <= cor_next[k][i];
        end
    end

    // Trig rounding (sin/cos) combined into first product stage
    function automatic coef_t trig_round(input logic signed [34:0] v, input logic neg);
        logic signed [34:0] r;
        coef_t c;
        r = (v + (35'sd1 <<< (29 - CoefFrac))) >>> (30 - CoefFrac);
        if (r > (35'sd1 <<< CoefFrac))
            r = 35'sd1 <<< CoefFrac;
        else if (r < -(35'sd1 <<< CoefFrac))
            r = -(35'sd1 <<< CoefFrac);
        c = r[CoefWidth-1:0];
        return neg ? -c : c;
    endfunction

    // Stage A: trig values, quaternion products, first Euler products
    coef_t    sf_reg, cf_reg, st_reg, ct_reg, sp_reg, cp_reg, sfst_reg, cfst_reg;
    logic signed [QprodWidth-1:0] qp_reg [10];
    in_item_t ia_reg;

    always_ff @(posedge clk)
    begin
        coef_t sf, cf, st, ct, sp, cp;
        if (advance)
        begin
            sf = trig_round(cor_reg[0][TrigStages].y, cor_reg[0][TrigStages].neg);
            cf = trig_round(cor_reg[0][TrigStages].x, cor_reg[0][TrigStages].neg);
            st = trig_round(cor_reg[1][TrigStages].y, cor_reg[1][TrigStages].neg);
            ct = trig_round(cor_reg[1][TrigStages].x, cor_reg[1][TrigStages].neg);
            sp = trig_round(cor_reg[2][TrigStages].y, cor_reg[2][TrigStages].neg);
            cp = trig_round(cor_reg[2][TrigStages].x, cor_reg[2][TrigStages].neg);
            sf_reg   <= sf;
            cf_reg   <= cf;
            st_reg   <= st;
            ct_reg   <= ct;
            sp_reg   <= sp;
            cp_reg   <= cp;
            sfst_reg <= mulr(sf, st);
            cfst_reg <= mulr(cf, st);
            ia_reg   <= itm_reg[TrigStages];
            qp_reg[0] <= itm_reg[TrigStages].quat_w * itm_reg[TrigStages].quat_w;
            qp_reg[1] <= itm_reg[TrigStages].quat_x * itm_reg[TrigStages].quat_x;
            qp_reg[2] <= itm_reg[TrigStages].quat_y * itm_reg[TrigStages].quat_y;
            qp_reg[3] <= itm_reg[TrigStages].quat_z * itm_reg[TrigStages].quat_z;
            qp_reg[4] <= itm_reg[TrigStages].quat_x * itm_reg[TrigStages].quat_y;
            qp_reg[5] <= itm_reg[TrigStages].quat_w * itm_reg[TrigStages].quat_z;
            qp_reg[6] <= itm_reg[TrigStages].quat_x * itm_reg[TrigStages].quat_z;
            qp_reg[7] <= itm_reg[TrigStages].quat_w * itm_reg[TrigStages].quat_y;
            qp_reg[8] <= itm_reg[TrigStages].quat_y * itm_reg[TrigStages].quat_z;
            qp_reg[9] <= itm_reg[TrigStages].quat_w * itm_reg[TrigStages].quat_x;
        end
    end

    // Stage B: rotation matrix
    coef_t    m_reg [9];
    in_item_t ib_reg;

    always_ff @(posedge clk)
    begin
        coef_t a01, a02, a10, a12, a20, a21;
        logic signed [QprodWidth+3:0] t;
        if (advance)
        begin
            ib_reg <= ia_reg;
            if (ia_reg.op == OP_EULER)
            begin
                m_reg[0] <= mulr(ct_reg, cp_reg);
                m_reg[1] <= mulr(ct_reg, sp_reg);
                m_reg[2] <= clamp_coef(-(QprodWidth+4)'(st_reg));
                t = (QprodWidth+4)'(mulr(sfst_reg, cp_reg)) - (QprodWidth+4)'(mulr(cf_reg, sp_reg));
                m_reg[3] <= clamp_coef(t);
                t = (QprodWidth+4)'(mulr(sfst_reg, sp_reg)) + (QprodWidth+4)'(mulr(cf_reg, cp_reg));
                m_reg[4] <= clamp_coef(t);
                m_reg[5] <= mulr(sf_reg, ct_reg);
                t = (QprodWidth+4)'(mulr(cfst_reg, cp_reg)) + (QprodWidth+4)'(mulr(sf_reg, sp_reg));
                m_reg[6] <= clamp_coef(t);
                t = (QprodWidth+4)'(mulr(cfst_reg, sp_reg)) - (QprodWidth+4)'(mulr(sf_reg, cp_reg));
                m_reg[7] <= clamp_coef(t);
                m_reg[8] <= mulr(cf_reg, ct_reg);
            end
            else
            begin
                a01 = quat_entry(qp_reg[4], qp_reg[5], 1'b0);
                a02 = quat_entry(qp_reg[6], -qp_reg[7], 1'b0);
                a10 = quat_entry(qp_reg[4], -qp_reg[5], 1'b0);
                a12 = quat_entry(qp_reg[8], qp_reg[9], 1'b0);
                a20 = quat_entry(qp_reg[6], qp_reg[7], 1'b0);
                a21 = quat_entry(qp_reg[8], -qp_reg[9], 1'b0);
                m_reg[0] <= quat_entry(qp_reg[0], qp_reg[1], 1'b1);
                m_reg[4] <= quat_entry(qp_reg[0], qp_reg[2], 1'b1);
                m_reg[8] <= quat_entry(qp_reg[0], qp_reg[3], 1'b1);
                if (ia_reg.op == OP_QUAT)
                begin
                    m_reg[1] <= a01; m_reg[2] <= a02; m_reg[3] <= a10;
                    m_reg[5] <= a12; m_reg[6] <= a20; m_reg[7] <= a21;
                end
                else
                begin
                    m_reg[1] <= a10; m_reg[2] <= a20; m_reg[3] <= a01;
                    m_reg[5] <= a21; m_reg[6] <= a02; m_reg[7] <= a12;
                end
            end
        end
    end

    // Stage C: nine products; stage D: sums and rounding; stage E: saturation
    logic signed [VectorWidth+CoefWidth-1:0] p_reg [9];
    logic signed [SumWidth-1:0] s_reg [3];
    out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        vec_t v [3];
        logic signed [SumWidth-1:0] r;
        logic signed [SumWidth-1:0] vmax, vmin;
        logic sat;
        vec_t rr [3];
        if (advance)
        begin
            v[0] = ib_reg.vec_x;
            v[1] = ib_reg.vec_y;
            v[2] = ib_reg.vec_z;
            for (int k = 0; k < 9; k++)
                p_reg[k] <= m_reg[k] * v[k % 3];
            for (int k = 0; k < 3; k++)
            begin
                r = SumWidth'(p_reg[3*k]) + SumWidth'(p_reg[3*k+1]) + SumWidth'(p_reg[3*k+2])
                    + (SumWidth'(1) <<< (CoefFrac - 1));
                s_reg[k] <= r >>> CoefFrac;
            end
            vmax = SumWidth'({1'b0, {(VectorWidth-1){1'b1}}});
            vmin = -vmax - SumWidth'(1);
            sat = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                if (s_reg[k] > vmax)
                begin
                    rr[k] = vmax[VectorWidth-1:0];
                    sat = 1'b1;
                end
                else if (s_reg[k] < vmin)
                begin
                    rr[k] = vmin[VectorWidth-1:0];
                    sat = 1'b1;
                end
                else
                    rr[k] = s_reg[k][VectorWidth-1:0];
            end
            out_reg.rot_x     <= rr[0];
            out_reg.rot_y     <= rr[1];
            out_reg.rot_z     <= rr[2];
            out_reg.saturated <= sat;
        end
    end

    assign out_ch.data = out_reg;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("pipeline stalled with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> vld_reg[0])
        else $error("accepted transaction lost");
`endif

endmodule
